/* hw/rtl/safa_pkg.sv */
`default_nettype none

package safa_pkg;

   localparam int unsigned INDEX_W = 16;
   localparam int unsigned COEF_W  = 32;
   localparam int unsigned TDATA_W = 48;

   localparam logic signed [COEF_W-1:0] COEF_MAX = {1'b0, {(COEF_W-1){1'b1}}};
   localparam logic signed [COEF_W-1:0] COEF_MIN = {1'b1, {(COEF_W-1){1'b0}}};

   // one stored or emitted term, index in the low bits
   typedef struct packed {
      logic signed [COEF_W-1:0] coef;
      logic [INDEX_W-1:0]       index;
   } term_type;

   // which list heads the current merge step consumes
   typedef struct packed {
      logic take_a;
      logic take_b;
   } pick_type;

endpackage

`default_nettype wire

/* hw/rtl/safa_merge_pick.sv */
`default_nettype none

module safa_merge_pick (
   input  var safa_pkg::term_type a_term,
   input  var safa_pkg::term_type b_term,
   input  var logic               a_avail,
   input  var logic               b_avail,
   output safa_pkg::pick_type     pick,
   output safa_pkg::term_type     out_term
);
   import safa_pkg::*;

   logic signed [COEF_W:0] wide_sum;
   logic signed [COEF_W-1:0] sat_sum;

   always_comb begin
      wide_sum = {a_term.coef[COEF_W-1], a_term.coef} + {b_term.coef[COEF_W-1], b_term.coef};
      if (wide_sum[COEF_W] != wide_sum[COEF_W-1]) begin
         sat_sum = wide_sum[COEF_W] ? COEF_MIN : COEF_MAX;
      end else begin
         sat_sum = wide_sum[COEF_W-1:0];
      end
   end

   always_comb begin
      pick     = '0;
      out_term = a_term;
      if (!b_avail || (a_avail && (a_term.index < b_term.index))) begin
         pick.take_a = 1'b1;
         out_term    = a_term;
      end else if (!a_avail || (b_term.index < a_term.index)) begin
         pick.take_b = 1'b1;
         out_term    = b_term;
      end else begin
         // equal heads: sum and saturate
         pick.take_a   = 1'b1;
         pick.take_b   = 1'b1;
         out_term.index = a_term.index;
         out_term.coef  = sat_sum;
      end
   end

endmodule

`default_nettype wire

/* hw/rtl/sparse_affine_form_add_top.sv */
`default_nettype none

// sum of two sparse affine forms. each item on the req side is one term:
// req_tuser picks the operand (0 first, 1 second), req_tlast marks the last
// term of that operand's list. terms load one per cycle into two term
// memories; up to MAX_TERMS terms per list are kept and later ones dropped.
// the second operand's last term starts a two-pointer merge: a priming
// state reads both list heads, then one merged term leaves per cycle while
// rsp_tready does not stall the output (ascending index, equal indices
// summed with Q16.16 saturation). at most 2*MAX_TERMS-1 terms are emitted
// and the final one carries rsp_tlast. no items are taken during the merge;
// loading resumes as soon as the last term sits in the output register.
module sparse_affine_form_add_top #(
   parameter int unsigned MAX_TERMS = 32
) (
   input  var logic        clock,
   input  var logic        reset,
   // request side
   input  var logic        req_tvalid,
   output logic            req_tready,
   input  var logic [47:0] req_tdata,  // noise_index [15:0], coefficient [47:16]
   input  var logic [0:0]  req_tuser,  // operand_sel
   input  var logic        req_tlast,  // last_term
   // result side
   output logic            rsp_tvalid,
   input  var logic        rsp_tready,
   output logic [47:0]     rsp_tdata,  // sum_index [15:0], sum_coefficient [47:16]
   output logic            rsp_tlast   // last_out
);
   import safa_pkg::*;

   localparam int unsigned AW = $clog2(MAX_TERMS);
   localparam int unsigned CW = $clog2(MAX_TERMS + 1);
   localparam int unsigned KW = $clog2(2 * MAX_TERMS);

   typedef enum logic [2:0] {
      ST_LOAD  = 3'b001,
      ST_PRIME = 3'b010,
      ST_MERGE = 3'b100
   } state_type;

   state_type state_ff, state_in;

   // term memories
   term_type first_mem  [MAX_TERMS];
   term_type second_mem [MAX_TERMS];
   term_type rd_a_ff, rd_b_ff;

   logic [CW-1:0] first_count_ff, first_count_in;
   logic [CW-1:0] second_count_ff, second_count_in;
   logic [CW-1:0] i_ff, i_in;
   logic [CW-1:0] j_ff, j_in;
   logic [KW-1:0] k_ff, k_in;

   logic     rsp_valid_ff, rsp_valid_in;
   logic     rsp_last_ff, rsp_last_in;
   term_type rsp_term_ff, rsp_term_in;

   term_type req_term;
   logic     req_fire;
   logic     wr_first, wr_second;
   logic     trigger;
   logic     a_avail, b_avail;
   logic     advance;
   logic     final_term;
   pick_type pick;
   term_type merged_term;

   assign req_term   = req_tdata[TDATA_W-1:0];
   assign req_tready = (state_ff == ST_LOAD);
   assign req_fire   = req_tvalid && req_tready;
   assign wr_first   = req_fire && !req_tuser[0] && (first_count_ff < CW'(MAX_TERMS));
   assign wr_second  = req_fire && req_tuser[0] && (second_count_ff < CW'(MAX_TERMS));
   assign trigger    = req_fire && req_tuser[0] && req_tlast;

   assign a_avail = (i_ff < first_count_ff);
   assign b_avail = (j_ff < second_count_ff);
   // a merge step only goes when the output register is free or draining
   assign advance = (state_ff == ST_MERGE) && (!rsp_valid_ff || rsp_tready);

   safa_merge_pick u_pick (
      .a_term   (rd_a_ff),
      .b_term   (rd_b_ff),
      .a_avail  (a_avail),
      .b_avail  (b_avail),
      .pick     (pick),
      .out_term (merged_term)
   );

   always_comb begin
      state_in        = state_ff;
      first_count_in  = first_count_ff;
      second_count_in = second_count_ff;
      i_in            = i_ff;
      j_in            = j_ff;
      k_in            = k_ff;
      rsp_valid_in    = rsp_valid_ff && !rsp_tready;
      rsp_last_in     = rsp_last_ff;
      rsp_term_in     = rsp_term_ff;
      final_term      = 1'b0;

      unique case (state_ff)
         ST_LOAD: begin
            if (wr_first) begin
               first_count_in = first_count_ff + CW'(1);
            end
            if (wr_second) begin
               second_count_in = second_count_ff + CW'(1);
            end
            if (trigger) begin
               i_in     = '0;
               j_in     = '0;
               k_in     = '0;
               state_in = ST_PRIME;
            end
         end
         ST_PRIME: begin
            // heads at address zero are being read
            state_in = ST_MERGE;
         end
         ST_MERGE: begin
            if (advance) begin
               i_in = i_ff + CW'(pick.take_a);
               j_in = j_ff + CW'(pick.take_b);
               k_in = k_ff + KW'(1);
               final_term = ((i_in >= first_count_ff) && (j_in >= second_count_ff))
                            || (k_ff == KW'(2 * MAX_TERMS - 2));
               rsp_valid_in = 1'b1;
               rsp_term_in  = merged_term;
               rsp_last_in  = final_term;
               if (final_term) begin
                  first_count_in  = '0;
                  second_count_in = '0;
                  state_in        = ST_LOAD;
               end
            end
         end
         default: begin
            state_in = ST_LOAD;
         end
      endcase
   end

   // write port during load, read port follows the next head pointers
   always_ff @(posedge clock) begin
      if (wr_first) begin
         first_mem[first_count_ff[AW-1:0]] <= req_term;
      end
      rd_a_ff <= first_mem[i_in[AW-1:0]];
   end

   always_ff @(posedge clock) begin
      if (wr_second) begin
         second_mem[second_count_ff[AW-1:0]] <= req_term;
      end
      rd_b_ff <= second_mem[j_in[AW-1:0]];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= ST_LOAD;
         first_count_ff  <= '0;
         second_count_ff <= '0;
         i_ff            <= '0;
         j_ff            <= '0;
         k_ff            <= '0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         state_ff        <= state_in;
         first_count_ff  <= first_count_in;
         second_count_ff <= second_count_in;
         i_ff            <= i_in;
         j_ff            <= j_in;
         k_ff            <= k_in;
         rsp_valid_ff    <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_term_ff <= rsp_term_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_term_ff;
   assign rsp_tlast  = rsp_last_ff;

`ifndef ASSERT_OFF
   a_state_onehot : assert property (@(posedge clock) disable iff (reset)
      $onehot(state_ff))
      else $error("state register not one-hot");

   a_merge_has_work : assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_MERGE) |-> (a_avail || b_avail))
      else $error("merge running with both lists exhausted");

   a_ptr_bound : assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_MERGE) |-> ((i_ff <= first_count_ff) && (j_ff <= second_count_ff)))
      else $error("merge pointer past list end");

   a_out_bound : assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_MERGE) |-> (k_ff <= KW'(2 * MAX_TERMS - 2)))
      else $error("merge emitted too many terms");

   a_last_ends_merge : assert property (@(posedge clock) disable iff (reset)
      (advance && final_term) |=> (state_ff == ST_LOAD) && rsp_tvalid && rsp_tlast)
      else $error("final term did not end the merge");
`endif

endmodule

`default_nettype wire
